### rtl/slam_pkg.sv
// Shared types and constants of the syscall lookahead anomaly monitor.
`default_nettype none
package slam_pkg;

    localparam int CALL_W  = 9;
    localparam int TIME_W  = 48;
    localparam int CNT_W   = 32;
    localparam int LIM_W   = 16;
    localparam int MISM_W  = 4;
    localparam int CFG_IDX_W = 2;

    typedef logic [1:0] t_op;
    localparam t_op OP_EVENT    = 2'd0;
    localparam t_op OP_CLR_WIN  = 2'd1;
    localparam t_op OP_CLR_PROF = 2'd2;
    localparam t_op OP_RSVD     = 2'd3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ANOMALY_LIMIT = 2'd0;
    localparam t_cfg_idx CFG_NORMAL_FACTOR = 2'd1;
    localparam t_cfg_idx CFG_FACTOR_DEN    = 2'd2;
    localparam t_cfg_idx CFG_NORMAL_WAIT   = 2'd3;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    typedef struct packed {
        t_op               op;
        logic [CALL_W-1:0] syscall_number;
        logic [TIME_W-1:0] now;
    } t_in_item;

    typedef struct packed {
        logic [CALL_W-1:0] call_seen;
        logic [MISM_W-1:0] mismatch_count;
        logic              anomaly_flag;
        logic              normal_mode;
        logic              frozen_flag;
        logic              table_updated;
    } t_out_item;

    typedef struct packed {
        logic [LIM_W-1:0]  anomaly_limit;
        logic [LIM_W-1:0]  normal_factor;
        logic [LIM_W-1:0]  normal_factor_den;
        logic [TIME_W-1:0] normal_wait;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic rd;
        logic chk;
        logic ev1;
        logic ev2;
        logic ev3;
        logic ev4;
        logic ev5;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic in_event;
        logic in_wipe;
        logic clr_last;
        logic scan_done;
    } t_sts;

endpackage
`default_nettype wire

### rtl/slam_ctrl.sv
// Sequencing state machine of the monitor.
`default_nettype none
module slam_ctrl import slam_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  wire  i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [10:0] {
        S_INIT = 11'b000_0000_0001,
        S_IDLE = 11'b000_0000_0010,
        S_WIPE = 11'b000_0000_0100,
        S_RD   = 11'b000_0000_1000,
        S_CHK  = 11'b000_0001_0000,
        S_EV1  = 11'b000_0010_0000,
        S_EV2  = 11'b000_0100_0000,
        S_EV3  = 11'b000_1000_0000,
        S_EV4  = 11'b001_0000_0000,
        S_EV5  = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.in_event)     n_state = S_RD;
                    else if (i_sts.in_wipe) n_state = S_WIPE;
                    else                    n_state = S_DONE;
                end
            end
            S_WIPE: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_DONE;
            end
            S_RD: begin
                if (i_sts.scan_done) begin
                    n_state = S_EV1;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = S_RD;
            end
            S_EV1: begin o_cmd.ev1 = 1'b1; n_state = S_EV2; end
            S_EV2: begin o_cmd.ev2 = 1'b1; n_state = S_EV3; end
            S_EV3: begin o_cmd.ev3 = 1'b1; n_state = S_EV4; end
            S_EV4: begin o_cmd.ev4 = 1'b1; n_state = S_EV5; end
            S_EV5: begin o_cmd.ev5 = 1'b1; n_state = S_DONE; end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out)  n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
        else                  n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

### rtl/slam_dpath.sv
// Window, lookahead table memory, profile counters and result register.
`default_nettype none
module slam_dpath import slam_pkg::*; #(
    parameter int SYSCALLS = 512,
    parameter int SEQ_LEN  = 9
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  t_in_item  i_in,
    input  t_cfg      i_cfg,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output t_out_item o_out
);

    localparam int DEPTH = SYSCALLS * SYSCALLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(SEQ_LEN);
    localparam int CW    = $clog2(SEQ_LEN + 1);

    logic [7:0]        r_mem [DEPTH];
    logic [7:0]        r_rd_data;
    logic [AW-1:0]     r_addr;
    logic [AW-1:0]     r_clr_addr;

    logic [CALL_W-1:0] r_win [SEQ_LEN];
    logic [CW-1:0]     r_fill;
    logic [CW-1:0]     r_d;

    logic [TIME_W-1:0] r_now;
    logic [CALL_W-1:0] r_call_out;
    logic [MISM_W-1:0] r_mism;
    logic              r_anom;
    logic              r_upd;

    logic              r_normal, r_frozen;
    logic [CNT_W-1:0]  r_anom_total, r_train, r_stable;
    logic [TIME_W-1:0] r_deadline;
    logic [CNT_W-1:0]  r_ncount;
    logic [CNT_W+LIM_W-1:0] r_prod_train, r_prod_norm;

    t_out_item         r_out;

    logic              in_range;
    logic [AW-1:0]     pair_addr;
    logic [2:0]        bit_pos;
    logic [7:0]        bit_mask;
    logic              miss;
    logic [CNT_W:0]    anom_sum, train_sum, stable_sum;
    logic [TIME_W:0]   dl_sum;

    assign in_range  = 32'(i_in.syscall_number) < SYSCALLS;
    assign pair_addr = AW'(32'(r_win[0]) * SYSCALLS + 32'(r_win[r_d[IW-1:0]]));
    assign bit_pos   = 3'(r_d - CW'(1));
    assign bit_mask  = 8'(1) << bit_pos;
    assign miss      = (r_rd_data & bit_mask) == 8'd0;
    assign anom_sum  = {1'b0, r_anom_total} + (CNT_W+1)'(r_mism);
    assign train_sum = {1'b0, r_train} + (CNT_W+1)'(1);
    assign stable_sum = {1'b0, r_stable} + (CNT_W+1)'(1);
    assign dl_sum    = {1'b0, r_now} + {1'b0, i_cfg.normal_wait};

    assign o_sts.in_event  = (i_in.op == OP_EVENT) && in_range;
    assign o_sts.in_wipe   = (i_in.op == OP_CLR_PROF);
    assign o_sts.clr_last  = (r_clr_addr == AW'(DEPTH - 1));
    assign o_sts.scan_done = (r_d >= r_fill);

    // table memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) r_mem[r_clr_addr] <= 8'd0;
        else if (i_cmd.chk && miss) r_mem[r_addr] <= r_rd_data | bit_mask;
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[pair_addr];
            r_addr    <= pair_addr;
        end
    end

    // window taps, shifted from the top down
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && o_sts.in_event) begin
            for (int i = SEQ_LEN - 1; i > 0; i--) r_win[i] <= r_win[i-1];
            r_win[0] <= i_in.syscall_number;
        end
    end

    // item payload and per-item results
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_now      <= i_in.now;
            r_call_out <= (i_in.op == OP_EVENT) ? i_in.syscall_number : '0;
            r_mism     <= '0;
            r_anom     <= 1'b0;
            r_upd      <= 1'b0;
            r_d        <= CW'(1);
        end
        if (i_cmd.chk) begin
            r_d <= r_d + CW'(1);
            if (miss) begin
                r_mism <= r_mism + MISM_W'(1);
                r_upd  <= 1'b1;
            end
        end
        if (i_cmd.ev1) r_anom <= r_normal && (r_mism != '0);
        if (i_cmd.ev2) r_ncount <= (r_train > r_stable) ? r_train - r_stable : '0;
        if (i_cmd.ev3) begin
            r_prod_train <= r_train * i_cfg.normal_factor_den;
            r_prod_norm  <= r_ncount * i_cfg.normal_factor;
        end
        if (i_cmd.load_out) begin
            r_out.call_seen      <= r_call_out;
            r_out.mismatch_count <= r_mism;
            r_out.anomaly_flag   <= r_anom;
            r_out.normal_mode    <= r_normal;
            r_out.frozen_flag    <= r_frozen;
            r_out.table_updated  <= r_upd;
        end
    end

    // profile state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_clr_addr   <= '0;
            r_normal     <= 1'b0;
            r_frozen     <= 1'b0;
            r_anom_total <= '0;
            r_train      <= '0;
            r_stable     <= '0;
            r_deadline   <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= o_sts.clr_last ? '0 : r_clr_addr + AW'(1);
            end
            if (i_cmd.accept) begin
                if (o_sts.in_event && r_fill < CW'(SEQ_LEN)) r_fill <= r_fill + CW'(1);
                if (i_in.op == OP_CLR_WIN) r_fill <= '0;
                if (o_sts.in_wipe) begin
                    r_clr_addr   <= '0;
                    r_normal     <= 1'b0;
                    r_frozen     <= 1'b0;
                    r_anom_total <= '0;
                    r_train      <= '0;
                    r_stable     <= '0;
                    r_deadline   <= '0;
                end
            end
            if (i_cmd.ev1) begin
                if (r_normal && r_mism != '0) begin
                    if (r_anom_total > CNT_W'(i_cfg.anomaly_limit)) r_normal <= 1'b0;
                    r_anom_total <= anom_sum[CNT_W] ? CNT_MAX : anom_sum[CNT_W-1:0];
                end
                r_train <= train_sum[CNT_W] ? CNT_MAX : train_sum[CNT_W-1:0];
                if (r_mism != '0) begin
                    r_frozen <= 1'b0;
                    r_stable <= '0;
                end else begin
                    r_stable <= stable_sum[CNT_W] ? CNT_MAX : stable_sum[CNT_W-1:0];
                end
            end
            if (i_cmd.ev4 && r_mism == '0 && !r_frozen && r_ncount != '0
                && r_prod_train > r_prod_norm) begin
                r_frozen   <= 1'b1;
                r_deadline <= dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];
            end
            if (i_cmd.ev5 && r_frozen && r_now > r_deadline) begin
                r_normal     <= 1'b1;
                r_frozen     <= 1'b0;
                r_anom_total <= '0;
                r_stable     <= '0;
            end
        end
    end

    assign o_out = r_out;

endmodule
`default_nettype wire

### rtl/syscall_lookahead_anomaly_monitor_unit.sv
// Top level of the syscall lookahead anomaly monitor with its register file.
//
//  channel | signals                                | direction
//  --------+----------------------------------------+-----------
//  in      | i_in_valid / o_in_ready / i_in         | item in
//  out     | o_out_valid / i_out_ready / o_out      | result out
//  cfg     | i_cfg_valid / o_cfg_ready / i_cfg_index, i_cfg_data | register write
//
// A syscall event first scans its window: for each pair in it, a read state and then
// a check/write-back state on the table. The scan ends in the read state; five counter
// states (EV1..EV5) and the load state follow. Window clears, unused ops and
// out-of-range calls go straight to the load state; a profile clear first sweeps all
// SYSCALLS*SYSCALLS table bytes (262144 by default), one byte a cycle. The same sweep
// runs after reset, and no item is taken until it ends; cfg writes are always taken.
// The next item can be taken in the cycle after the load. The result register lets a
// new item in while the last result waits; a second result stalls until it is taken.
`default_nettype none
module syscall_lookahead_anomaly_monitor_unit import slam_pkg::*; #(
    parameter int SYSCALLS = 512,
    parameter int SEQ_LEN  = 9
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output t_out_item         o_out,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  t_cfg_idx          i_cfg_index,
    input  wire [TIME_W-1:0]  i_cfg_data
);

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;

    // register file: a write transfer is taken at any time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.anomaly_limit     <= LIM_W'(30);
            r_cfg.normal_factor     <= LIM_W'(128);
            r_cfg.normal_factor_den <= LIM_W'(32);
            r_cfg.normal_wait       <= TIME_W'(1000000);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ANOMALY_LIMIT: r_cfg.anomaly_limit     <= i_cfg_data[LIM_W-1:0];
                CFG_NORMAL_FACTOR: r_cfg.normal_factor     <= i_cfg_data[LIM_W-1:0];
                CFG_FACTOR_DEN:    r_cfg.normal_factor_den <= i_cfg_data[LIM_W-1:0];
                CFG_NORMAL_WAIT:   r_cfg.normal_wait       <= i_cfg_data;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    slam_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    slam_dpath #(
        .SYSCALLS (SYSCALLS),
        .SEQ_LEN  (SEQ_LEN)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

### dv/slam_checker.sv
// Result checker for the syscall lookahead anomaly monitor.
`default_nettype none
module slam_checker import slam_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire               i_in_ready,
    input  t_in_item          i_in,
    input  wire               i_out_valid,
    input  wire               i_out_ready,
    input  t_out_item         i_out,
    input  wire               i_cfg_valid,
    input  wire               i_cfg_ready,
    input  t_cfg_idx          i_cfg_index,
    input  wire [TIME_W-1:0]  i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);
    localparam int NCALLS = 512;
    localparam int DEPTH  = 9;

    logic [7:0]        pair_bits [NCALLS*NCALLS];
    logic [CALL_W-1:0] recent [DEPTH];
    int unsigned       recent_fill;
    logic              in_normal, is_frozen;
    logic [CNT_W-1:0]  anomalies, trained, stable;
    logic [TIME_W-1:0] deadline;
    t_cfg              cfg;
    t_out_item         pending_results [$];

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    task automatic wipe_profile();
        foreach (pair_bits[k]) pair_bits[k] = '0;
        in_normal = 0; is_frozen = 0;
        anomalies = 0; trained = 0; stable = 0; deadline = 0;
    endtask

    task automatic predict_step(input t_in_item it, output t_out_item r);
        int unsigned miss;
        logic [63:0] ncount;
        logic [TIME_W:0] sum;
        r = '0;
        miss = 0;
        if (it.op == OP_CLR_WIN) begin
            recent_fill = 0;
        end else if (it.op == OP_CLR_PROF) begin
            wipe_profile();
        end else if (it.op == OP_EVENT) begin
            r.call_seen = it.syscall_number;
            for (int i = DEPTH - 1; i > 0; i--) recent[i] = recent[i-1];
            recent[0] = it.syscall_number;
            if (recent_fill < DEPTH) recent_fill++;
            for (int d = 1; d < recent_fill; d++)
                if (!pair_bits[recent[0]*NCALLS + recent[d]][d-1]) miss++;
            if (in_normal && miss != 0) begin
                r.anomaly_flag = 1;
                if (anomalies > CNT_W'(cfg.anomaly_limit)) in_normal = 0;
                anomalies = sat_inc(anomalies, miss);
            end
            trained = sat_inc(trained, 1);
            if (miss != 0) begin
                is_frozen = 0;
                for (int d = 1; d < recent_fill; d++)
                    pair_bits[recent[0]*NCALLS + recent[d]][d-1] = 1'b1;
                stable = 0;
                r.table_updated = 1;
            end else begin
                stable = sat_inc(stable, 1);
                if (!is_frozen) begin
                    ncount = (trained > stable) ? 64'(trained - stable) : 64'd0;
                    if (ncount != 0 && 64'(trained) * 64'(cfg.normal_factor_den) >
                        ncount * 64'(cfg.normal_factor)) begin
                        is_frozen = 1;
                        sum = {1'b0, it.now} + {1'b0, cfg.normal_wait};
                        deadline = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                    end
                end
            end
            if (is_frozen && it.now > deadline) begin
                in_normal = 1; is_frozen = 0; anomalies = 0; stable = 0;
            end
        end
        r.mismatch_count = MISM_W'(miss);
        r.normal_mode = in_normal;
        r.frozen_flag = is_frozen;
    endtask

    initial begin
        o_fail_count = 0;
        recent_fill = 0;
        foreach (recent[i]) recent[i] = '0;
        cfg = '{16'd30, 16'd128, 16'd32, 48'd1000000};
        wipe_profile();
    end

    assign o_pending = pending_results.size();

    always @(posedge i_clk) begin
        t_out_item want, got;
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ANOMALY_LIMIT: cfg.anomaly_limit     = i_cfg_data[LIM_W-1:0];
                    CFG_NORMAL_FACTOR: cfg.normal_factor     = i_cfg_data[LIM_W-1:0];
                    CFG_FACTOR_DEN:    cfg.normal_factor_den = i_cfg_data[LIM_W-1:0];
                    CFG_NORMAL_WAIT:   cfg.normal_wait       = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, got);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_step(i_in, want);
                pending_results.push_back(want);
            end
        end
    end
endmodule
`default_nettype wire

### dv/testbench.sv
// Stimulus and verdict for the syscall lookahead anomaly monitor.
`default_nettype none
module testbench import slam_pkg::*;;
    logic             clk = 0;
    logic             rst_n = 0;
    logic             in_valid = 0;
    logic             in_ready;
    t_in_item         in_item = '0;
    logic             out_valid;
    logic             out_ready = 0;
    t_out_item        out_item;
    logic             cfg_valid = 0;
    logic             cfg_ready;
    t_cfg_idx         cfg_index = CFG_ANOMALY_LIMIT;
    logic [TIME_W-1:0] cfg_data = '0;
    int               fail_count, pending;
    int               quiet_cycles = 0;
    logic             calm = 0;           // last stretch: no idling on either side
    logic [TIME_W-1:0] clock_now = 0;

    // Watchdog limit: covers the profile-clear sweep of 262144 table bytes, plus stall margin.
    localparam int STALL_LIMIT = 1_200_000;

    always begin
        #2 clk = 1;
        #2 clk = 0;
    end

    syscall_lookahead_anomaly_monitor_unit i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out(out_item),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    slam_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in(in_item),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out(out_item),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: ready toggles in random bursts, steady high once calm.
    initial begin
        int n;
        @(posedge clk iff rst_n);
        forever begin
            if (calm) begin
                out_ready <= 1;
                @(posedge clk);
            end else begin
                out_ready <= $urandom_range(0, 1);
                n = $urandom_range(1, 13);
                repeat (n) @(posedge clk);
            end
        end
    end

    // Watchdog: any transfer resets the count.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // Valid stays high into the next send; a gap or a drain drops it.
    task automatic send(input t_op op, input logic [CALL_W-1:0] call);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        // Time stamps mostly creep forward, sometimes jump.
        case ($urandom_range(0, 9))
            0: clock_now = TIME_W'({$urandom, $urandom});
            1: clock_now = TIME_MAX - TIME_W'($urandom_range(0, 3));
            default: clock_now = clock_now + TIME_W'($urandom_range(0, 50));
        endcase
        in_valid <= 1;
        in_item <= '{op, call, clock_now};
        @(posedge clk iff in_ready);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [TIME_W-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk iff cfg_ready);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk iff pending == 0);
        repeat (30) @(posedge clk);
    endtask

    // One phase of random traffic over a small alphabet of calls so pairs repeat.
    task automatic traffic(input int count, input int alphabet);
        int pick;
        logic [CALL_W-1:0] base;
        base = 9'($urandom_range(0, 511 - alphabet));
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 88)
                send(OP_EVENT, base + 9'($urandom_range(0, alphabet - 1)));
            else if (pick < 93) send(OP_EVENT, 9'($urandom_range(0, 511)));
            else if (pick < 98) send(OP_CLR_WIN, 9'($urandom_range(0, 511)));
            else                send(OP_RSVD, 9'($urandom_range(0, 511)));
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1;

        // Extremes of the registers before any traffic.
        write_reg(CFG_ANOMALY_LIMIT, 48'd0);
        write_reg(CFG_NORMAL_FACTOR, 48'd1);
        write_reg(CFG_FACTOR_DEN, 48'd65535);
        write_reg(CFG_NORMAL_WAIT, 48'd0);

        // Directed: field extremes, every op, quick freeze and normal entry.
        send(OP_EVENT, 9'd0);
        send(OP_EVENT, 9'd511);
        send(OP_EVENT, 9'd0);
        send(OP_EVENT, 9'd511);
        for (int i = 0; i < 10; i++) send(OP_EVENT, 9'(i % 2 ? 511 : 0));
        send(OP_EVENT, 9'd300);   // unseen pair while in normal mode
        send(OP_CLR_WIN, 9'd511);
        send(OP_EVENT, 9'd5);
        send(OP_RSVD, 9'd7);
        send(OP_CLR_PROF, 9'd0);
        drain();   // sender holds off until every result is back

        write_reg(CFG_ANOMALY_LIMIT, 48'd65535);
        write_reg(CFG_NORMAL_FACTOR, 48'd65535);
        write_reg(CFG_FACTOR_DEN, 48'd1);
        write_reg(CFG_NORMAL_WAIT, TIME_MAX);
        traffic(150, 4);
        drain();

        write_reg(CFG_ANOMALY_LIMIT, 48'd3);
        write_reg(CFG_NORMAL_FACTOR, 48'd2);
        write_reg(CFG_FACTOR_DEN, 48'd3);
        write_reg(CFG_NORMAL_WAIT, 48'd20);
        traffic(250, 5);
        drain();

        write_reg(CFG_ANOMALY_LIMIT, 48'd30);
        write_reg(CFG_NORMAL_FACTOR, 48'd128);
        write_reg(CFG_FACTOR_DEN, 48'd32);
        write_reg(CFG_NORMAL_WAIT, 48'd100);
        traffic(200, 3);
        calm = 1;
        traffic(150, 6);
        send(OP_CLR_PROF, 9'd0);
        in_valid <= 0;

        @(posedge clk iff pending == 0);
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
rtl/slam_pkg.sv
rtl/slam_ctrl.sv
rtl/slam_dpath.sv
rtl/syscall_lookahead_anomaly_monitor_unit.sv
dv/slam_checker.sv
dv/testbench.sv
